FILE: hw/rtl/psg_pkg.sv
// Shared types and constants for the post-shift settle guard.
`timescale 1ns / 1ps

package psg_pkg;

    localparam int TimeW   = 32;
    localparam int EpochW  = 32;
    localparam int ErrW    = 16;
    localparam int CountW  = 8;
    localparam int CfgW    = 16;
    localparam int CfgIdxW = 2;

    localparam int InBits   = TimeW + 3 + ErrW + EpochW;
    localparam int InDataW  = ((InBits + 7) / 8) * 8;
    localparam int OutDataW = 8;

    typedef enum logic [1:0] {
        REASON_NONE     = 2'd0,
        REASON_SHIFT    = 2'd1,
        REASON_MISMATCH = 2'd2,
        REASON_SETTLING = 2'd3
    } reason_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MIN_SETTLE  = 2'd0,
        CFG_ERR_LIMIT   = 2'd1,
        CFG_STABLE_NEED = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [EpochW-1:0]      sample_epoch;
        logic signed [ErrW-1:0] ratio_err;
        logic                   sample_valid;
        logic                   gear_conflict;
        logic                   shift_active;
        logic [TimeW-1:0]       time_ms;
    } tick_t;

    localparam logic [CfgW-1:0]   MinSettleReset  = 16'd300;
    localparam logic [CfgW-1:0]   ErrLimitReset   = 16'd50;
    localparam logic [CountW-1:0] StableNeedReset = 8'd3;
    localparam logic [CountW-1:0] CountMax        = 8'hFF;

endpackage

FILE: hw/rtl/post_shift_settle_guard_top.sv
// Post-shift settle guard: input register, guard update and result register.
//
//  channel  | signals                                   | item
//  ---------+-------------------------------------------+----------------------------
//  s_axis   | s_axis_tvalid/tready/tdata[87:0]          | one control tick
//  m_axis   | m_axis_tvalid/tready/tdata[7:0]           | guard_reason
//  cfg      | cfg_wr_en, cfg_index[1:0], cfg_data[15:0] | register write
//
// One item per cycle unless the result stalls; each goes through both registers.
// The guard state updates as an item moves from the input register to the
// result register, so consecutive items see each other's updates in order.
// A stalled result holds; the input register keeps accepting while the
// result register is free or being drained in the same cycle.
// rst_n clears the valid flags, guard state and the registers to defaults.
`timescale 1ns / 1ps

module post_shift_settle_guard_top
    import psg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // time_ms[31:0], shift_active[32], gear_conflict[33], sample_valid[34],
    // ratio_err[50:35], sample_epoch[82:51], zeros[87:83]
    input  logic [InDataW-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // guard_reason[1:0], zeros[7:2]
    output logic [OutDataW-1:0] m_axis_tdata,
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgW-1:0]     cfg_data
);

    logic [CfgW-1:0]   min_settle_reg;
    logic [CfgW-1:0]   err_limit_reg;
    logic [CountW-1:0] stable_need_reg;

    logic              in_valid_reg;
    tick_t             in_tick_reg;
    logic              out_valid_reg;
    reason_t           out_reason_reg;

    logic              was_inhibited_reg, was_inhibited_next;
    logic              settling_reg, settling_next;
    logic [TimeW-1:0]  settle_start_reg, settle_start_next;
    logic [CountW-1:0] stable_count_reg, stable_count_next;
    logic [EpochW-1:0] last_epoch_reg, last_epoch_next;
    reason_t           reason_next;

    logic              out_free;
    logic              process;
    logic [TimeW-1:0]  start_eff;
    logic [TimeW-1:0]  elapsed;
    logic [EpochW-1:0] epoch_eff;
    logic [CountW-1:0] count_eff;
    logic [CountW-1:0] count_upd;
    logic [ErrW:0]     err_ext;
    logic [ErrW:0]     err_abs;
    logic              sample_ok;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign process       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OutDataW - 2){1'b0}}, out_reason_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_settle_reg  <= MinSettleReset;
            err_limit_reg   <= ErrLimitReset;
            stable_need_reg <= StableNeedReset;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MIN_SETTLE:  min_settle_reg  <= cfg_data;
                CFG_ERR_LIMIT:   err_limit_reg   <= cfg_data;
                CFG_STABLE_NEED: stable_need_reg <= cfg_data[CountW-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_tick_reg <= tick_t'(s_axis_tdata[InBits-1:0]);
        end
    end

    // Guard update
    always_comb
    begin
        err_ext   = {in_tick_reg.ratio_err[ErrW-1], in_tick_reg.ratio_err};
        err_abs   = err_ext[ErrW] ? ((ErrW + 1)'(0) - err_ext) : err_ext;
        sample_ok = in_tick_reg.sample_valid && (err_abs <= {1'b0, err_limit_reg});

        start_eff = was_inhibited_reg ? in_tick_reg.time_ms : settle_start_reg;
        epoch_eff = was_inhibited_reg ? in_tick_reg.sample_epoch : last_epoch_reg;
        count_eff = was_inhibited_reg ? '0 : stable_count_reg;
        elapsed   = in_tick_reg.time_ms - start_eff;

        if (!sample_ok)
            count_upd = '0;
        else if (count_eff != CountMax)
            count_upd = count_eff + CountW'(1);
        else
            count_upd = count_eff;

        was_inhibited_next = was_inhibited_reg;
        settling_next      = settling_reg;
        settle_start_next  = settle_start_reg;
        stable_count_next  = stable_count_reg;
        last_epoch_next    = last_epoch_reg;
        reason_next        = REASON_NONE;

        if (in_tick_reg.shift_active || in_tick_reg.gear_conflict)
        begin
            was_inhibited_next = 1'b1;
            settling_next      = 1'b0;
            stable_count_next  = '0;
            last_epoch_next    = in_tick_reg.sample_epoch;
            reason_next        = in_tick_reg.shift_active ? REASON_SHIFT : REASON_MISMATCH;
        end
        else if (was_inhibited_reg || settling_reg)
        begin
            was_inhibited_next = 1'b0;
            settle_start_next  = start_eff;
            stable_count_next  = count_eff;
            last_epoch_next    = epoch_eff;
            settling_next      = 1'b1;
            reason_next        = REASON_SETTLING;
            if (elapsed >= {{(TimeW - CfgW){1'b0}}, min_settle_reg})
            begin
                if (in_tick_reg.sample_epoch != epoch_eff)
                begin
                    last_epoch_next   = in_tick_reg.sample_epoch;
                    stable_count_next = count_upd;
                end
                if (stable_count_next >= stable_need_reg)
                begin
                    settling_next = 1'b0;
                    reason_next   = REASON_NONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_inhibited_reg <= 1'b0;
            settling_reg      <= 1'b0;
            settle_start_reg  <= '0;
            stable_count_reg  <= '0;
            last_epoch_reg    <= '0;
            out_valid_reg     <= 1'b0;
            out_reason_reg    <= REASON_NONE;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (process)
            begin
                was_inhibited_reg <= was_inhibited_next;
                settling_reg      <= settling_next;
                settle_start_reg  <= settle_start_next;
                stable_count_reg  <= stable_count_next;
                last_epoch_reg    <= last_epoch_next;
                out_reason_reg    <= reason_next;
            end
        end
    end

    a_inhibit_state: assert property (@(posedge clk) disable iff (!rst_n)
        process && (in_tick_reg.shift_active || in_tick_reg.gear_conflict)
        |=> was_inhibited_reg && !settling_reg && stable_count_reg == '0)
        else $error("inhibit did not clear settle state");

    a_shift_wins: assert property (@(posedge clk) disable iff (!rst_n)
        process && in_tick_reg.shift_active
        |=> out_valid_reg && out_reason_reg == REASON_SHIFT)
        else $error("shift inhibit not reported");

    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(was_inhibited_reg && settling_reg))
        else $error("inhibited and settling at once");

    a_settle_reason: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> (settling_reg == (out_reason_reg == REASON_SETTLING)))
        else $error("settling flag disagrees with reported reason");

endmodule
